// ===== hdl/scan_device_dedup_table_defines.svh =====
// assertion macros shared by the scan device dedup table modules
`ifndef SCAN_DEVICE_DEDUP_TABLE_DEFINES_SVH
`define SCAN_DEVICE_DEDUP_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk and held off during reset
`define SDD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk and held off during reset
`define SDD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sdd_pkg.sv =====
// types and constants of the scan device dedup table
`timescale 1ns / 1ps

package sdd_pkg;

    // command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_FIND  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // address type reported when an address is absent
    localparam logic [7:0] TYPE_PUBLIC = 8'd0;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [47:0]        dev_addr;
        logic [7:0]         dev_type;
        logic signed [7:0]  signal_dbm;
    } sdd_req_t;

    typedef struct packed {
        logic               hit;
        logic               added;
        logic               dropped;
        logic [3:0]         slot;
        logic [7:0]         type_out;
        logic signed [7:0]  best_dbm;
        logic [4:0]         used;
    } sdd_rsp_t;

    // one stored table entry
    typedef struct packed {
        logic [47:0]        addr;
        logic [7:0]         dev_type;
        logic signed [7:0]  strength;
    } sdd_entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } sdd_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic match;
        logic scan_done;
    } sdd_stat_t;

endpackage

// ===== hdl/sdd_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module sdd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/sdd_ctrl.sv =====
// sequencing state machine of the scan device dedup table
`timescale 1ns / 1ps
`include "scan_device_dedup_table_defines.svh"

module sdd_ctrl
    import sdd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  sdd_stat_t stat,
    output sdd_ctrl_t ctrl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        ctrl           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctrl.scan = 1'b1;
                if (stat.match || stat.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                ctrl.finish    = 1'b1;
                rsp_valid_next = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                if (rsp_ready)
                begin
                    rsp_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // checks
    `SDD_ASSERT_IMPL(a_one_item, rsp_valid_reg, !req_ready, "new item taken while result pending")
    `SDD_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0(ctrl), "more than one datapath command")
    `SDD_ASSERT_NEXT(a_finish_out, ctrl.finish, rsp_valid_reg, "result not shown after finish")

endmodule

// ===== hdl/sdd_datapath.sv =====
// table storage, search and update logic of the scan device dedup table
`timescale 1ns / 1ps
`include "scan_device_dedup_table_defines.svh"

module sdd_datapath
    import sdd_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  sdd_req_t  req,
    input  sdd_ctrl_t ctrl,
    output sdd_stat_t stat,
    output sdd_rsp_t  rsp
);

    localparam int IDXW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNTW = $clog2(MAX_ENTRIES + 1);
    localparam int EW   = $bits(sdd_entry_t);
    localparam logic [CNTW-1:0] FULL_COUNT = CNTW'(MAX_ENTRIES);

    sdd_req_t         item_reg;
    logic [CNTW-1:0]  count_reg;
    logic [CNTW-1:0]  count_next;
    logic [CNTW-1:0]  issue_reg;
    logic [IDXW-1:0]  cmp_idx_reg;
    logic             rd_vld_reg;
    logic             hit_reg;
    logic [IDXW-1:0]  hit_idx_reg;
    sdd_entry_t       hit_entry_reg;
    sdd_rsp_t         rsp_reg;
    sdd_rsp_t         rsp_next;

    logic             is_lookup;
    logic             rd_en;
    logic [EW-1:0]    rd_data;
    sdd_entry_t       rd_entry;
    logic             match;
    logic             full;
    logic             wr_en;
    logic [IDXW-1:0]  wr_addr;
    sdd_entry_t       wr_entry;
    logic [IDXW-1:0]  sel_idx;
    logic [IDXW+3:0]  slot_wide;
    logic [CNTW+4:0]  used_wide;
    logic signed [7:0] new_strength;

    assign is_lookup = (item_reg.cmd == CMD_ADD) || (item_reg.cmd == CMD_FIND);
    assign full      = (count_reg >= FULL_COUNT);

    // linear search: one read issued per cycle, compared in the cycle after
    assign rd_entry = sdd_entry_t'(rd_data);
    assign match    = rd_vld_reg && is_lookup && (rd_entry.addr == item_reg.dev_addr);
    assign rd_en    = ctrl.scan && is_lookup && !match && (issue_reg < count_reg);

    assign stat.match     = match;
    assign stat.scan_done = !is_lookup || ((issue_reg >= count_reg) && !rd_vld_reg);

    sdd_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[IDXW-1:0]),
        .rd_data (rd_data)
    );

    // result, table write and count update on finish
    always_comb
    begin
        rsp_next     = '0;
        count_next   = count_reg;
        wr_en        = 1'b0;
        wr_addr      = count_reg[IDXW-1:0];
        new_strength = item_reg.signal_dbm;
        wr_entry     = '{addr: item_reg.dev_addr, dev_type: item_reg.dev_type,
                         strength: item_reg.signal_dbm};
        sel_idx      = hit_reg ? hit_idx_reg : count_reg[IDXW-1:0];
        slot_wide    = {4'b0, sel_idx};
        unique case (item_reg.cmd)
            CMD_ADD:
            begin
                if (hit_reg)
                begin
                    new_strength = (item_reg.signal_dbm > hit_entry_reg.strength) ?
                                   item_reg.signal_dbm : hit_entry_reg.strength;
                    wr_entry          = hit_entry_reg;
                    wr_entry.strength = new_strength;
                    wr_addr           = hit_idx_reg;
                    wr_en             = ctrl.finish;
                    rsp_next.hit      = 1'b1;
                    rsp_next.slot     = slot_wide[3:0];
                    rsp_next.type_out = hit_entry_reg.dev_type;
                    rsp_next.best_dbm = new_strength;
                end
                else if (full)
                begin
                    rsp_next.dropped = 1'b1;
                end
                else
                begin
                    wr_en             = ctrl.finish;
                    count_next        = count_reg + 1'b1;
                    rsp_next.added    = 1'b1;
                    rsp_next.slot     = slot_wide[3:0];
                    rsp_next.type_out = item_reg.dev_type;
                    rsp_next.best_dbm = item_reg.signal_dbm;
                end
            end
            CMD_FIND:
            begin
                if (hit_reg)
                begin
                    rsp_next.hit      = 1'b1;
                    rsp_next.slot     = slot_wide[3:0];
                    rsp_next.type_out = hit_entry_reg.dev_type;
                    rsp_next.best_dbm = hit_entry_reg.strength;
                end
                else
                begin
                    rsp_next.type_out = TYPE_PUBLIC;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            CMD_NONE:
            begin
                count_next = count_reg;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        used_wide     = {5'b0, count_next};
        rsp_next.used = used_wide[4:0];
    end

    // control state: count, search pointers, hit flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            issue_reg  <= '0;
            rd_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= rd_en;
            if (ctrl.load)
            begin
                issue_reg <= '0;
                hit_reg   <= 1'b0;
            end
            else if (rd_en)
            begin
                issue_reg <= issue_reg + 1'b1;
            end
            if (ctrl.scan && match)
            begin
                hit_reg <= 1'b1;
            end
            if (ctrl.finish)
            begin
                count_reg <= count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            item_reg <= req;
        end
        if (rd_en)
        begin
            cmp_idx_reg <= issue_reg[IDXW-1:0];
        end
        if (ctrl.scan && match)
        begin
            hit_idx_reg   <= cmp_idx_reg;
            hit_entry_reg <= rd_entry;
        end
        if (ctrl.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

    // checks
    `SDD_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= FULL_COUNT, "entry count above table size")
    `SDD_ASSERT_NEXT(a_append_count, ctrl.finish && wr_en && !hit_reg, count_reg == $past(count_reg) + 1'b1, "append did not grow count")

endmodule

// ===== hdl/scan_device_dedup_table.sv =====
// Duplicate filter for discovered radio devices: holds up to MAX_ENTRIES
// 48-bit addresses with address type and strongest signal, answering add,
// find and clear commands with one result each. One item is handled at a
// time, from transfer in to result shown: load, one table read per valid
// entry through the single read port of the entry ram with the read data
// registered, a step to see the search end, finish, result. Clear and the
// unused command do no table reads. A search stops at the first matching
// entry. The next request is taken once the result has been transferred
// out.
`timescale 1ns / 1ps

module scan_device_dedup_table
    import sdd_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  sdd_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output sdd_rsp_t rsp
);

    sdd_ctrl_t ctrl;
    sdd_stat_t stat;

    // sequencer
    sdd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // table and search datapath
    sdd_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ctrl  (ctrl),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule
